FILE: rtl/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg: shared definitions for the stack machine executor
// Opcodes, word width, controller command/status bundles and opcode decode.
// ----------------------------------------------------------------------------
`default_nettype none

package smx_pkg;

  localparam int WORD_W          = 16;
  localparam int NUM_GEN         = 6;
  localparam int STACK_DEPTH_DEF = 256;

  // Opcodes
  localparam logic [4:0] OP_PUSH  = 5'd0;
  localparam logic [4:0] OP_POP   = 5'd1;
  localparam logic [4:0] OP_ADD   = 5'd2;
  localparam logic [4:0] OP_SUB   = 5'd3;
  localparam logic [4:0] OP_MUL   = 5'd4;
  localparam logic [4:0] OP_DIV   = 5'd5;
  localparam logic [4:0] OP_MOD   = 5'd6;
  localparam logic [4:0] OP_LOAD  = 5'd7;
  localparam logic [4:0] OP_STORE = 5'd8;
  localparam logic [4:0] OP_CMP   = 5'd9;
  localparam logic [4:0] OP_JMP   = 5'd10;
  localparam logic [4:0] OP_JZ    = 5'd11;
  localparam logic [4:0] OP_JNZ   = 5'd12;
  localparam logic [4:0] OP_JE    = 5'd13;
  localparam logic [4:0] OP_JNE   = 5'd14;
  localparam logic [4:0] OP_JGT   = 5'd15;
  localparam logic [4:0] OP_JLT   = 5'd16;
  localparam logic [4:0] OP_JGE   = 5'd17;
  localparam logic [4:0] OP_JLE   = 5'd18;
  localparam logic [4:0] OP_DUP   = 5'd19;
  localparam logic [4:0] OP_HALT  = 5'd20;

  // Special load indexes
  localparam logic [15:0] LD_SP = 16'd6;
  localparam logic [15:0] LD_PC = 16'd7;
  localparam logic [15:0] LD_SF = 16'd8;
  localparam logic [15:0] LD_ZF = 16'd9;

  // Controller to datapath
  typedef struct packed {
    logic latch_item;   // capture request
    logic latch_y;      // capture top of stack
    logic rd_below;     // read address one below top
    logic latch_x;      // capture second operand
    logic calc;         // register result word
    logic div_start;    // kick off divider
    logic commit;       // update state and result register
  } smx_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic halted;
    logic in_reads;     // incoming op reads the top of stack
    logic binary;       // latched op takes two operands
    logic div_nz;       // latched op is div/mod with non-zero divisor
    logic div_done;
  } smx_stat_t;

  function automatic logic op_reads(input logic [4:0] f);
    logic r;
    case (f) inside
      OP_POP, OP_STORE, OP_DUP, OP_ADD, OP_SUB, OP_MUL,
      OP_DIV, OP_MOD, OP_CMP: r = 1'b1;
      default:               r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic op_binary(input logic [4:0] f);
    logic r;
    case (f) inside
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_CMP: r = 1'b1;
      default:                                       r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/smx_div.sv
// ----------------------------------------------------------------------------
// smx_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [smx_pkg::WORD_W-1:0] dividend_i,
  input  logic [smx_pkg::WORD_W-1:0] divisor_i,
  output logic [smx_pkg::WORD_W-1:0] quot_o,
  output logic [smx_pkg::WORD_W-1:0] rem_o,
  output logic                      done_o
);
  import smx_pkg::*;

  localparam int CW = $clog2(WORD_W);

  logic            busy_q, busy_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [WORD_W-1:0] quo_q, quo_d, rem_q, rem_d, dsr_q, dsr_d;
  logic [WORD_W:0] shifted, trial;

  // one trial subtraction per cycle
  always_comb begin
    shifted = {rem_q, quo_q[WORD_W-1]};
    trial   = shifted - {1'b0, dsr_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[WORD_W]) begin
        rem_d = trial[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(WORD_W - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = busy_q && !busy_d;
  assign quot_o = quo_d;
  assign rem_o  = rem_d;

endmodule

`default_nettype wire

FILE: rtl/smx_dp.sv
// ----------------------------------------------------------------------------
// smx_dp: stack machine datapath
// Operand stack memory, registers, ALU, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_dp #(
  parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  smx_pkg::smx_cmd_t          cmd_i,
  output smx_pkg::smx_stat_t         stat_o,
  input  logic [4:0]                 func_i,
  input  logic signed [15:0]         operand_i,
  output logic [15:0]                next_pc_o,
  output logic signed [15:0]         pop_value_o,
  output logic                       pop_valid_o,
  output logic                       zero_out_o,
  output logic                       sign_out_o,
  output logic                       halted_out_o,
  output logic                       stack_fault_o,
  output logic                       div_fault_o
);
  import smx_pkg::*;

  localparam int SPW = $clog2(STACK_DEPTH);
  localparam logic [SPW-1:0] SP_TOP = SPW'(STACK_DEPTH - 1);
  localparam logic [SPW-1:0] SP_NXT = SPW'(STACK_DEPTH - 2);

  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic [SPW-1:0]    raddr, waddr;
  logic              we;
  logic [WORD_W-1:0] wdata;

  logic [4:0]        func_q;
  logic [15:0]       opnd_q;
  logic [WORD_W-1:0] x_q, y_q, r_q;
  logic              dfault_q;

  logic [SPW-1:0]    sp_q, sp_d, sp_p1, sp_m1, sp_m2;
  logic [15:0]       pc_q, pc_d;
  logic              zf_q, zf_d, sf_q, sf_d, halted_q, halted_d;
  logic [WORD_W-1:0] gen_q [NUM_GEN];
  logic              gen_we;

  logic [15:0]       pc_p1, pc_p2;
  logic              take, fault;
  logic [WORD_W-1:0] pval, ld_val;

  // divider on magnitudes
  logic              xn, yn;
  logic [WORD_W-1:0] ax, ay, quot, rem, div_res;
  logic              div_done;
  logic [2*WORD_W-1:0] prod;
  logic [WORD_W-1:0] alu_res;

  assign sp_p1 = (sp_q == SP_TOP) ? '0 : sp_q + 1'b1;
  assign sp_m1 = (sp_q == '0) ? SP_TOP : sp_q - 1'b1;
  assign sp_m2 = (sp_m1 == '0) ? SP_TOP : sp_m1 - 1'b1;
  assign raddr = cmd_i.rd_below ? sp_m1 : sp_q;

  // operand stack, registered read
  always_ff @(posedge clk_i) begin
    if (we) stack_mem[waddr] <= wdata;
    rdata_q <= stack_mem[raddr];
  end

  // request and operand capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      func_q <= func_i;
      opnd_q <= operand_i;
    end
    if (cmd_i.latch_y) y_q <= rdata_q;
    if (cmd_i.latch_x) x_q <= rdata_q;
  end

  assign xn = x_q[WORD_W-1];
  assign yn = y_q[WORD_W-1];
  assign ax = xn ? WORD_W'(-x_q) : x_q;
  assign ay = yn ? WORD_W'(-y_q) : y_q;

  smx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (ax),
    .divisor_i  (ay),
    .quot_o     (quot),
    .rem_o      (rem),
    .done_o     (div_done)
  );

  always_comb begin
    if (func_q == OP_DIV) div_res = (xn != yn) ? WORD_W'(-quot) : quot;
    else                  div_res = xn ? WORD_W'(-rem) : rem;
  end

  assign prod = x_q * y_q;

  // add, sub/cmp, mul, and zero for a zero divisor
  always_comb begin
    case (func_q)
      OP_ADD:  alu_res = x_q + y_q;
      OP_MUL:  alu_res = prod[WORD_W-1:0];
      OP_SUB,
      OP_CMP:  alu_res = x_q - y_q;
      default: alu_res = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      r_q      <= (stat_o.div_nz) ? div_res : alu_res;
      dfault_q <= (func_q == OP_DIV || func_q == OP_MOD) && (y_q == '0);
    end
  end

  assign pc_p1 = pc_q + 16'd1;
  assign pc_p2 = pc_q + 16'd2;

  // load source select
  always_comb begin
    if (opnd_q < 16'(NUM_GEN)) ld_val = gen_q[opnd_q[2:0]];
    else if (opnd_q == LD_SP)  ld_val = WORD_W'(sp_q);
    else if (opnd_q == LD_PC)  ld_val = pc_p1;
    else if (opnd_q == LD_SF)  ld_val = WORD_W'(sf_q);
    else if (opnd_q == LD_ZF)  ld_val = WORD_W'(zf_q);
    else                       ld_val = '0;
  end

  // next state for the instruction being retired
  always_comb begin
    sp_d     = sp_q;
    pc_d     = pc_p1;
    zf_d     = zf_q;
    sf_d     = sf_q;
    halted_d = halted_q;
    we       = 1'b0;
    waddr    = sp_p1;
    wdata    = y_q;
    gen_we   = 1'b0;
    take     = 1'b0;
    fault    = 1'b0;
    pval     = '0;
    case (func_q)
      OP_PUSH, OP_LOAD: begin
        pc_d  = pc_p2;
        we    = 1'b1;
        wdata = (func_q == OP_PUSH) ? opnd_q : ld_val;
        sp_d  = sp_p1;
        fault = (sp_p1 == SP_TOP);
      end
      OP_POP: begin
        pval  = y_q;
        sp_d  = sp_m1;
        fault = (sp_q == SP_TOP);
      end
      OP_STORE: begin
        pc_d   = pc_p2;
        gen_we = (opnd_q < 16'(NUM_GEN));
        sp_d   = sp_m1;
        fault  = (sp_q == SP_TOP);
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        we    = 1'b1;
        waddr = sp_m1;
        wdata = r_q;
        sp_d  = sp_m1;
        zf_d  = (r_q == '0);
        sf_d  = r_q[WORD_W-1];
        fault = (sp_q == SP_TOP) || (sp_q == '0);
      end
      OP_CMP: begin
        sp_d  = sp_m2;
        zf_d  = (r_q == '0);
        sf_d  = r_q[WORD_W-1];
        fault = (sp_q == SP_TOP) || (sp_q == '0);
      end
      OP_DUP: begin
        we    = 1'b1;
        sp_d  = sp_p1;
        fault = (sp_q == SP_TOP) || (sp_q == SP_NXT);
      end
      OP_JMP:        begin pc_d = pc_p2; take = 1'b1;          end
      OP_JZ, OP_JE:  begin pc_d = pc_p2; take = zf_q;          end
      OP_JNZ, OP_JNE: begin pc_d = pc_p2; take = !zf_q;        end
      OP_JGT:        begin pc_d = pc_p2; take = !sf_q;         end
      OP_JLT:        begin pc_d = pc_p2; take = sf_q;          end
      OP_JGE:        begin pc_d = pc_p2; take = !sf_q || zf_q; end
      OP_JLE:        begin pc_d = pc_p2; take = sf_q || zf_q;  end
      OP_HALT:       halted_d = 1'b1;
      default: ;
    endcase
    if (take) pc_d = opnd_q;
    // halted: nothing moves
    if (halted_q) begin
      sp_d     = sp_q;
      pc_d     = pc_q;
      zf_d     = zf_q;
      sf_d     = sf_q;
      we       = 1'b0;
      gen_we   = 1'b0;
      fault    = 1'b0;
      pval     = '0;
    end
    we = we && cmd_i.commit;
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= SP_TOP;
      pc_q     <= '0;
      zf_q     <= 1'b0;
      sf_q     <= 1'b0;
      halted_q <= 1'b0;
      for (int i = 0; i < NUM_GEN; i++) gen_q[i] <= '0;
    end else if (cmd_i.commit) begin
      sp_q     <= sp_d;
      pc_q     <= pc_d;
      zf_q     <= zf_d;
      sf_q     <= sf_d;
      halted_q <= halted_d;
      if (gen_we) gen_q[opnd_q[2:0]] <= y_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      next_pc_o     <= pc_d;
      pop_value_o   <= pval;
      pop_valid_o   <= !halted_q && (func_q == OP_POP);
      zero_out_o    <= zf_d;
      sign_out_o    <= sf_d;
      halted_out_o  <= halted_d;
      stack_fault_o <= fault;
      div_fault_o   <= !halted_q && op_binary(func_q) && func_q != OP_CMP && dfault_q
                       && (func_q == OP_DIV || func_q == OP_MOD);
    end
  end

  assign stat_o.halted   = halted_q;
  assign stat_o.in_reads = op_reads(func_i);
  assign stat_o.binary   = op_binary(func_q);
  assign stat_o.div_nz   = (func_q == OP_DIV || func_q == OP_MOD) && (y_q != '0);
  assign stat_o.div_done = div_done;

endmodule

`default_nettype wire

FILE: rtl/smx_ctrl.sv
// ----------------------------------------------------------------------------
// smx_ctrl: stack machine sequencer
// Steps each request through the operand reads and compute its opcode needs, then retire.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output smx_pkg::smx_cmd_t  cmd_o,
  input  smx_pkg::smx_stat_t stat_i
);
  import smx_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d = (!stat_i.halted && stat_i.in_reads) ? S_EXEC : S_WB;
        end
      end
      S_EXEC: begin
        cmd_o.latch_y = 1'b1;
        if (stat_i.binary) begin
          cmd_o.rd_below = 1'b1;
          state_d = S_RD2;
        end else begin
          state_d = S_WB;
        end
      end
      S_RD2: begin
        cmd_o.latch_x = 1'b1;
        state_d = S_CALC;
      end
      S_CALC: begin
        if (stat_i.div_nz) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          cmd_o.calc = 1'b1;
          state_d = S_WB;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.calc = 1'b1;
          state_d = S_WB;
        end
      end
      S_WB: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("retire into occupied result register");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (state_q == S_DIV))
    else $error("divider started without wait state");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken while busy");
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("retired request lost");
`endif

endmodule

`default_nettype wire

FILE: rtl/stack_machine_executor.sv
// ----------------------------------------------------------------------------
// stack_machine_executor: 16-bit stack machine instruction executor
// One instruction per request; one result per request.
// ----------------------------------------------------------------------------
// Each request is one fetched instruction. Push, load, jumps, halt and
// requests after halt skip to retire; pop, store and dup do one registered
// stack memory read; add, sub, mul and cmp do two stack reads on the single
// read port, then compute; div and mod by a non-zero divisor wait on the
// one-bit-per-cycle divider. The result register lets a new request in while
// the previous result waits. The stack memory needs no clearing after reset.
`default_nettype none

module stack_machine_executor #(
  parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [4:0]         func_i,
  input  logic signed [15:0] operand_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        next_pc_o,
  output logic signed [15:0] pop_value_o,
  output logic               pop_valid_o,
  output logic               zero_out_o,
  output logic               sign_out_o,
  output logic               halted_out_o,
  output logic               stack_fault_o,
  output logic               div_fault_o
);
  import smx_pkg::*;

  smx_cmd_t  cmd;
  smx_stat_t stat;

  smx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  smx_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .func_i        (func_i),
    .operand_i     (operand_i),
    .next_pc_o     (next_pc_o),
    .pop_value_o   (pop_value_o),
    .pop_valid_o   (pop_valid_o),
    .zero_out_o    (zero_out_o),
    .sign_out_o    (sign_out_o),
    .halted_out_o  (halted_out_o),
    .stack_fault_o (stack_fault_o),
    .div_fault_o   (div_fault_o)
  );

endmodule

`default_nettype wire

FILE: tb/stack_machine_executor_tb.sv
// ----------------------------------------------------------------------------
// stack_machine_executor_tb: self-checking bench for the stack machine executor
// Requests go in over a valid/ready channel, and each result is compared field
// by field with a behavioural predictor kept in step. The test sequences are
// directed instructions, a full stack wrap, a long random program, a receiver
// hold-off that backs up the input, and a halt. Both sides insert random gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_executor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smx_pkg::*;

  localparam int          DEPTH      = 256;
  localparam int          IDLE_LIMIT = 20000;
  localparam int          HOLD_LEN   = 300;
  localparam logic [4:0]  OP_SPARE   = 5'd21;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [15:0] pop_value;
    logic        pop_valid;
    logic        zero;
    logic        sign;
    logic        halted;
    logic        stack_fault;
    logic        div_fault;
  } result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [4:0]         func_i;
  logic signed [15:0] operand_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [15:0]        next_pc_o;
  logic signed [15:0] pop_value_o;
  logic               pop_valid_o;
  logic               zero_out_o;
  logic               sign_out_o;
  logic               halted_out_o;
  logic               stack_fault_o;
  logic               div_fault_o;

  // Machine state as the bench sees it
  logic [15:0] mach_stack [DEPTH];
  logic        mach_written [DEPTH];
  logic [7:0]  mach_sp;
  logic [15:0] mach_regs [6];
  logic [15:0] mach_pc;
  logic        mach_zf;
  logic        mach_sf;
  logic        mach_halted;

  result_t     pending_results [$];
  int          mismatches;
  int          results_seen;
  int          requests_sent;
  int          idle_cycles;
  bit          tx_quiet;
  bit          rx_quiet;
  int          rx_hold;
  int          rx_gap;

  stack_machine_executor DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .operand_i,
    .out_valid_o, .out_ready_i, .next_pc_o, .pop_value_o, .pop_valid_o,
    .zero_out_o, .sign_out_o, .halted_out_o, .stack_fault_o, .div_fault_o
  );

  // Clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Stack helpers for the predictor
  task automatic stack_push(input logic [15:0] v, inout logic wrap);
    mach_sp = mach_sp + 8'd1;
    if (mach_sp == 8'(DEPTH - 1)) wrap = 1'b1;
    mach_stack[mach_sp]   = v;
    mach_written[mach_sp] = 1'b1;
  endtask

  task automatic stack_pop(output logic [15:0] v, inout logic wrap);
    v = mach_stack[mach_sp];
    if (mach_sp == 8'(DEPTH - 1)) wrap = 1'b1;
    mach_sp = mach_sp - 8'd1;
  endtask

  // True when the instruction would read a stack entry never written
  function automatic bit hits_unwritten(input logic [4:0] f);
    if (mach_halted) return 0;
    if (f inside {OP_POP, OP_STORE, OP_DUP}) return !mach_written[mach_sp];
    if (f inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_CMP})
      return !mach_written[mach_sp] || !mach_written[8'(mach_sp - 8'd1)];
    return 0;
  endfunction

  // Execute one instruction on the bench state and produce its result
  task automatic execute_instr(input logic [4:0] f, input logic [15:0] op,
                               output result_t r);
    logic [15:0] x, y, w;
    logic        wrap, take;
    r    = '0;
    wrap = 1'b0;
    take = 1'b0;
    x    = '0;
    y    = '0;
    w    = '0;
    if (mach_halted) begin
      r.next_pc = mach_pc;
      r.zero    = mach_zf;
      r.sign    = mach_sf;
      r.halted  = 1'b1;
      return;
    end
    r.next_pc = mach_pc + 16'd1;
    if (f inside {OP_PUSH, OP_LOAD, OP_STORE} || (f >= OP_JMP && f <= OP_JLE))
      r.next_pc = mach_pc + 16'd2;
    case (f)
      OP_PUSH: stack_push(op, wrap);
      OP_POP: begin
        stack_pop(x, wrap);
        r.pop_value = x;
        r.pop_valid = 1'b1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_CMP: begin
        stack_pop(y, wrap);
        stack_pop(x, wrap);
        case (f)
          OP_ADD:         w = x + y;
          OP_SUB, OP_CMP: w = x - y;
          OP_MUL:         w = x * y;
          default: begin
            if (y == 16'd0) begin
              w           = '0;
              r.div_fault = 1'b1;
            end else if (x == 16'h8000 && y == 16'hFFFF) begin
              w = (f == OP_DIV) ? 16'h8000 : 16'h0000;
            end else if (f == OP_DIV) begin
              w = $signed(x) / $signed(y);
            end else begin
              w = $signed(x) % $signed(y);
            end
          end
        endcase
        if (f != OP_CMP) stack_push(w, wrap);
        mach_zf = (w == 16'd0);
        mach_sf = w[15];
      end
      OP_LOAD: begin
        if (op < 16'd6)      x = mach_regs[op];
        else if (op == LD_SP) x = {8'd0, mach_sp};
        else if (op == LD_PC) x = mach_pc + 16'd1;
        else if (op == LD_SF) x = {15'd0, mach_sf};
        else if (op == LD_ZF) x = {15'd0, mach_zf};
        else                  x = '0;
        stack_push(x, wrap);
      end
      OP_STORE: begin
        stack_pop(x, wrap);
        if (op < 16'd6) mach_regs[op] = x;
      end
      OP_JMP:         take = 1'b1;
      OP_JZ, OP_JE:   take = mach_zf;
      OP_JNZ, OP_JNE: take = !mach_zf;
      OP_JGT:         take = !mach_sf;
      OP_JLT:         take = mach_sf;
      OP_JGE:         take = !mach_sf || mach_zf;
      OP_JLE:         take = mach_sf || mach_zf;
      OP_DUP: begin
        stack_pop(x, wrap);
        stack_push(x, wrap);
        stack_push(x, wrap);
      end
      OP_HALT: mach_halted = 1'b1;
      default: ;
    endcase
    if (take) r.next_pc = op;
    mach_pc       = r.next_pc;
    r.zero        = mach_zf;
    r.sign        = mach_sf;
    r.halted      = mach_halted;
    r.stack_fault = wrap;
  endtask

  function automatic int sender_gap();
    int p;
    p = $urandom_range(0, 99);
    if (tx_quiet || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one request; a read of an unwritten entry is turned into a push
  task automatic send_request(input logic [4:0] f, input logic [15:0] op);
    int      gap;
    result_t r;
    if (hits_unwritten(f)) begin
      f  = OP_PUSH;
      op = 16'($urandom);
    end
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    operand_i  <= op;
    do @(posedge clk_i); while (!in_ready_o);
    execute_instr(f, op, r);
    pending_results.push_back(r);
    requests_sent++;
  endtask

  // Receiver: random ready, optional long hold-off, result check
  always @(posedge clk_i) begin
    result_t got, want;
    if (out_valid_o && out_ready_i) begin
      got = '{next_pc_o, pop_value_o, pop_valid_o, zero_out_o, sign_out_o,
              halted_out_o, stack_fault_o, div_fault_o};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on result %0d: expected %p, got %p",
                     results_seen, want, got);
        end
      end
    end
    if (rx_hold > 0) begin
      out_ready_i <= 1'b0;
      rx_hold     <= rx_hold - 1;
    end else if (rx_gap > 0) begin
      out_ready_i <= 1'b0;
      rx_gap      <= rx_gap - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!rx_quiet && $urandom_range(0, 99) < 30)
        rx_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 3);
    end
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d results pending",
                 pending_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed: field extremes, every opcode but halt and the special cases
  task automatic test_directed();
    send_request(OP_PUSH, 16'h7FFF);
    send_request(OP_PUSH, 16'h0001);
    send_request(OP_ADD, '0);          // signed overflow wraps
    send_request(OP_PUSH, 16'h8000);
    send_request(OP_PUSH, 16'hFFFF);
    send_request(OP_DIV, '0);          // most negative over minus one
    send_request(OP_PUSH, 16'h8000);
    send_request(OP_PUSH, 16'hFFFF);
    send_request(OP_MOD, '0);
    send_request(OP_PUSH, 16'd0);
    send_request(OP_DIV, '0);          // zero divisor
    send_request(OP_PUSH, 16'd0);
    send_request(OP_MOD, '0);
    send_request(OP_PUSH, 16'hFFF9);   // -7
    send_request(OP_PUSH, 16'd2);
    send_request(OP_MOD, '0);
    send_request(OP_PUSH, 16'd3);
    send_request(OP_MUL, '0);
    send_request(OP_DUP, '0);
    send_request(OP_SUB, '0);
    send_request(OP_CMP, '0);
    send_request(OP_STORE, 16'd5);
    send_request(OP_STORE, 16'hFFFF);  // store to a special index drops it
    for (int i = 0; i <= 10; i++) send_request(OP_LOAD, 16'(i));
    send_request(OP_LOAD, 16'hFFFF);
    for (int f = OP_JMP; f <= OP_JLE; f++) send_request(5'(f), rand_word());
    send_request(5'd31, 16'hFFFF);     // unused opcode
    send_request(OP_POP, '0);
  endtask

  // Drain to empty, fill all entries so the last push wraps, pop past empty
  task automatic test_stack_wrap();
    while (mach_sp != 8'(DEPTH - 1)) send_request(OP_POP, '0);
    repeat (DEPTH) send_request(OP_PUSH, 16'($urandom));
    send_request(OP_POP, '0);
    repeat (DEPTH - 1) send_request(OP_POP, '0);
    send_request(OP_POP, '0);          // pop from empty
  endtask

  // Random program: mostly stack and arithmetic, some control flow and junk
  task automatic test_random(input int n);
    logic [4:0]  f;
    logic [15:0] op;
    for (int i = 0; i < n; i++) begin
      tx_quiet = (i >= n / 2 && i < n / 2 + 120);
      rx_quiet = tx_quiet;
      case ($urandom_range(0, 19))
        0, 1, 2, 3: f = OP_PUSH;
        4:          f = 5'($urandom_range(OP_SPARE, 31));
        5, 6:       f = 5'($urandom_range(OP_JMP, OP_JLE));
        7, 8:       f = $urandom_range(0, 1) ? OP_LOAD : OP_STORE;
        default:    f = 5'($urandom_range(OP_POP, OP_DUP));
      endcase
      if (f == OP_HALT) f = OP_DUP;
      op = rand_word();
      if ((f == OP_LOAD || f == OP_STORE) && $urandom_range(0, 3) != 0)
        op = 16'($urandom_range(0, 11));
      send_request(f, op);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Receiver holds off while requests keep coming
  task automatic test_backpressure();
    @(posedge clk_i);
    rx_hold  <= HOLD_LEN;
    tx_quiet = 1'b1;
    repeat (40) send_request(5'($urandom_range(OP_PUSH, OP_DUP)), rand_word());
    tx_quiet = 1'b0;
  endtask

  // Halt, then requests that must leave everything unchanged
  task automatic test_halt();
    send_request(OP_HALT, '0);
    repeat (10) send_request(5'($urandom), 16'($urandom));
  endtask

  initial begin
    int wait_cycles;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = '0;
    operand_i    = '0;
    out_ready_i  = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    requests_sent = 0;
    idle_cycles  = 0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    rx_hold      = 0;
    rx_gap       = 0;
    mach_sp      = 8'(DEPTH - 1);
    mach_pc      = '0;
    mach_zf      = 1'b0;
    mach_sf      = 1'b0;
    mach_halted  = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      mach_stack[i]   = '0;
      mach_written[i] = 1'b0;
    end
    for (int i = 0; i < 6; i++) mach_regs[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_stack_wrap();
    test_random(600);
    test_backpressure();
    test_random(150);
    test_halt();

    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    wait_cycles = 0;
    while (wait_cycles < 40) begin
      @(posedge clk_i);
      wait_cycles++;
    end

    $display("covered %0d requests and %0d results: directed ops, stack wrap,",
             requests_sent, results_seen);
    $display("random program, receiver hold-off and halt; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: stack_machine_executor.f
rtl/smx_pkg.sv
rtl/smx_div.sv
rtl/smx_dp.sv
rtl/smx_ctrl.sv
rtl/stack_machine_executor.sv
tb/stack_machine_executor_tb.sv
